>>> design/ssdcv_pkg.sv
// shared types and constants for the stereo ssd cost volume block
`default_nettype none
package ssdcv_pkg;

   localparam int PIX_W  = 8;
   localparam int COL_W  = 11;
   localparam int ROW_W  = 10;
   localparam int CFG_W  = 11;
   localparam int COST_W = 26;
   localparam int SUM_W  = COST_W - 2;
   localparam int DISP_W = 6;
   localparam int SQ_W   = 2 * PIX_W;
   localparam int MAX_HEIGHT = 1024;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-3:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-3:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

   typedef struct packed {
      logic [PIX_W-1:0] left_pixel;
      logic [PIX_W-1:0] right_pixel;
   } req_type;

   typedef struct packed {
      logic [COST_W-1:0] match_cost;
      logic [ROW_W-1:0]  centre_row;
      logic [ROW_W-1:0]  centre_col;
      logic [DISP_W-1:0] disparity;
      logic              last_of_run;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

>>> design/ssdcv_line_store.sv
// left and right line stores: one write port, one registered read port each
`default_nettype none
module ssdcv_line_store #(
   parameter int DEPTH  = 10240,
   parameter int ADDR_W = 14,
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_left,
   input  wire logic [DATA_W-1:0] wr_right,
   input  wire logic [ADDR_W-1:0] rd_addr_left,
   input  wire logic [ADDR_W-1:0] rd_addr_right,
   output logic      [DATA_W-1:0] rd_left,
   output logic      [DATA_W-1:0] rd_right
);

   logic [DATA_W-1:0] left_mem  [DEPTH];
   logic [DATA_W-1:0] right_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_mem[wr_addr]  <= wr_left;
         right_mem[wr_addr] <= wr_right;
      end
      rd_left  <= left_mem[rd_addr_left];
      rd_right <= right_mem[rd_addr_right];
   end

endmodule
`default_nettype wire

>>> design/stereo_ssd_cost_volume.sv
// top level: line stores plus a windowed ssd sequencer over one read port per store
// a pixel beat that completes no window leaves req_ready high; one that completes a
// window gives DISPARITIES costs, each held until rsp_ready, and req_ready stays low
// until the last cost is taken; one window pixel per cycle while a cost is summed,
// from the single read port of each line store; reset clears counters, control, the
// sum and configuration; other registers and line stores hold no reset value
`default_nettype none
module stereo_ssd_cost_volume #(
   parameter int WINDOW_HALF = 5,
   parameter int DISPARITIES = 50,
   parameter int MAX_WIDTH   = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire ssdcv_pkg::req_type                   req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output ssdcv_pkg::rsp_type                        rsp_data,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [ssdcv_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [ssdcv_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [ssdcv_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                      csr_pready
);
   import ssdcv_pkg::*;

   localparam int LINE_ROWS = 2 * WINDOW_HALF;
   localparam int DEPTH     = LINE_ROWS * MAX_WIDTH;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int WIN_W     = $clog2(LINE_ROWS);
   localparam int EMIT_COL  = WINDOW_HALF + DISPARITIES - 2;

   // configuration
   logic [CFG_W-1:0] frame_width_ff, frame_width_in;
   logic [CFG_W-1:0] frame_height_ff, frame_height_in;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      csr_prdata      = '0;
      case (csr_paddr[CSR_ADDR_W-1:2])
         REG_FRAME_WIDTH: begin
            csr_prdata = CSR_DATA_W'(frame_width_ff);
            if (csr_write) frame_width_in = csr_pwdata[CFG_W-1:0];
         end
         REG_FRAME_HEIGHT: begin
            csr_prdata = CSR_DATA_W'(frame_height_ff);
            if (csr_write) frame_height_in = csr_pwdata[CFG_W-1:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // effective frame size
   logic [COL_W-1:0] width_eff;
   logic [CFG_W-1:0] height_eff;

   always_comb begin
      width_eff = frame_width_ff;
      if (frame_width_ff == '0) width_eff = COL_W'(1);
      else if (frame_width_ff > COL_W'(MAX_WIDTH)) width_eff = COL_W'(MAX_WIDTH);
      height_eff = frame_height_ff;
      if (frame_height_ff == '0) height_eff = CFG_W'(1);
      else if (frame_height_ff > CFG_W'(MAX_HEIGHT)) height_eff = CFG_W'(MAX_HEIGHT);
   end

   // state
   state_type        state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [WIN_W-1:0] row_mod_ff, row_mod_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] ci_ff, ci_in;
   logic [COL_W-1:0] cj_ff, cj_in;
   logic [WIN_W-1:0] start_mod_ff, start_mod_in;
   logic [WIN_W-1:0] win_mod_ff, win_mod_in;
   logic [WIN_W-1:0] u_ff, u_in;
   logic [WIN_W-1:0] v_ff, v_in;
   logic [DISP_W-1:0] d_ff, d_in;
   logic             s1_valid_ff, s1_last_ff;
   logic             s2_valid_ff, s2_last_ff;
   logic [SQ_W-1:0]  sq_ff;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   // store ports
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr_left, rd_addr_right;
   logic [PIX_W-1:0]  rd_left, rd_right;
   logic              issue, issue_last;

   // per-beat decode
   logic              accept;
   logic [COL_W:0]    row_len, col_next;
   logic [COL_W-1:0]  cj_calc;
   logic [ROW_W:0]    row_next;
   logic              emit;
   logic [WIN_W-1:0]  mod_next;
   logic [COL_W-1:0]  win_col, right_col;
   logic [SUM_W-1:0]  sum_total;
   logic [PIX_W-1:0]  abs_diff;

   assign accept    = req_valid & req_ready;
   assign row_len   = (COL_W+1)'(width_eff) + (COL_W+1)'(DISPARITIES - 1);
   assign col_next  = (COL_W+1)'(col_ff) + 1'b1;
   assign row_next  = (ROW_W+1)'(row_ff) + 1'b1;
   assign cj_calc   = col_ff - COL_W'(EMIT_COL);
   assign mod_next  = (row_mod_ff == WIN_W'(LINE_ROWS - 1)) ? '0 : row_mod_ff + 1'b1;
   assign emit = (row_next >= (ROW_W+1)'(LINE_ROWS))
              && ((CFG_W+1)'(row_ff) + (CFG_W+1)'(2) <= (CFG_W+1)'(height_eff))
              && (col_ff >= COL_W'(EMIT_COL))
              && (cj_calc >= COL_W'(WINDOW_HALF))
              && ((COL_W+1)'(cj_calc) + (COL_W+1)'(WINDOW_HALF + 1)
                  <= (COL_W+1)'(width_eff));

   assign wr_en   = accept && (col_ff < width_eff);
   assign wr_addr = ADDR_W'(row_mod_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_ff);

   // window read addresses, right column clamps to the last real pixel
   assign win_col   = cj_ff - COL_W'(WINDOW_HALF) + COL_W'(v_ff);
   assign right_col = (win_col + COL_W'(d_ff) > width_eff - 1'b1)
                    ? width_eff - 1'b1 : win_col + COL_W'(d_ff);
   assign rd_addr_left  = ADDR_W'(win_mod_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(win_col);
   assign rd_addr_right = ADDR_W'(win_mod_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(right_col);

   ssdcv_line_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (PIX_W)
   ) u_store (
      .clock         (clock),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_left       (req_data.left_pixel),
      .wr_right      (req_data.right_pixel),
      .rd_addr_left  (rd_addr_left),
      .rd_addr_right (rd_addr_right),
      .rd_left       (rd_left),
      .rd_right      (rd_right)
   );

   assign abs_diff  = (rd_left >= rd_right) ? rd_left - rd_right : rd_right - rd_left;
   assign sum_total = acc_ff + SUM_W'(sq_ff);
   assign issue_last = (u_ff == WIN_W'(LINE_ROWS - 1)) && (v_ff == WIN_W'(LINE_ROWS - 1));

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      row_mod_in   = row_mod_ff;
      col_in       = col_ff;
      ci_in        = ci_ff;
      cj_in        = cj_ff;
      start_mod_in = start_mod_ff;
      win_mod_in   = win_mod_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      d_in         = d_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      issue        = 1'b0;

      if (s2_valid_ff) begin
         acc_in = s2_last_ff ? '0 : sum_total;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (col_next >= row_len) begin
                  col_in = '0;
                  if ((CFG_W+1)'(row_next) >= (CFG_W+1)'(height_eff)) begin
                     row_in     = '0;
                     row_mod_in = '0;
                  end else begin
                     row_in     = row_next[ROW_W-1:0];
                     row_mod_in = mod_next;
                  end
               end else begin
                  col_in = col_next[COL_W-1:0];
               end
               if (emit) begin
                  // window top row sits one line past the current row, modulo the store
                  ci_in        = row_next[ROW_W-1:0] - ROW_W'(WINDOW_HALF);
                  cj_in        = cj_calc;
                  start_mod_in = mod_next;
                  win_mod_in   = mod_next;
                  u_in         = '0;
                  v_in         = '0;
                  d_in         = '0;
                  state_in     = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            issue = 1'b1;
            if (v_ff == WIN_W'(LINE_ROWS - 1)) begin
               v_in       = '0;
               u_in       = u_ff + 1'b1;
               win_mod_in = (win_mod_ff == WIN_W'(LINE_ROWS - 1)) ? '0 : win_mod_ff + 1'b1;
            end else begin
               v_in = v_ff + 1'b1;
            end
            if (issue_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (s2_valid_ff && s2_last_ff) begin
               rsp_in.match_cost  = {sum_total, 2'b00};
               rsp_in.centre_row  = ci_ff;
               rsp_in.centre_col  = cj_ff[ROW_W-1:0];
               rsp_in.disparity   = d_ff;
               rsp_in.last_of_run = (d_ff == DISP_W'(DISPARITIES - 1));
               rsp_valid_in       = 1'b1;
               state_in           = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (d_ff == DISP_W'(DISPARITIES - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  d_in       = d_ff + 1'b1;
                  u_in       = '0;
                  v_in       = '0;
                  win_mod_in = start_mod_ff;
                  state_in   = ST_RUN;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         row_mod_ff   <= '0;
         col_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s1_last_ff   <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s2_last_ff   <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         row_mod_ff   <= row_mod_in;
         col_ff       <= col_in;
         s1_valid_ff  <= issue;
         s1_last_ff   <= issue & issue_last;
         s2_valid_ff  <= s1_valid_ff;
         s2_last_ff   <= s1_last_ff;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ci_ff        <= ci_in;
      cj_ff        <= cj_in;
      start_mod_ff <= start_mod_in;
      win_mod_ff   <= win_mod_in;
      u_ff         <= u_in;
      v_ff         <= v_in;
      d_ff         <= d_in;
      sq_ff        <= SQ_W'(abs_diff) * SQ_W'(abs_diff);
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// self-checking testbench for the stereo ssd cost volume block
`default_nettype none
module testbench;
   import ssdcv_pkg::*;

   localparam int HALF    = 5;
   localparam int NDISP   = 50;
   localparam int MAXW    = 1024;
   localparam int NROWS   = 2 * HALF;
   localparam int WDOG    = 20000;
   localparam int SETTLE  = 200;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   req_type req_data;
   rsp_type rsp_data;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;

   stereo_ssd_cost_volume uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // shadow of the block
   logic [PIX_W-1:0] left_mem [NROWS*MAXW];
   logic [PIX_W-1:0] right_mem [NROWS*MAXW];
   logic [CFG_W-1:0] width_reg, height_reg;
   int unsigned row_pos, col_pos;

   req_type pixel_q[$];
   rsp_type cost_q[$];
   int errors;
   int idle_cycles;
   logic req_taken;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned mem_at(int unsigned r, int unsigned c);
      return (r % NROWS) * MAXW + (c % MAXW);
   endfunction

   function automatic logic [COST_W-1:0] ssd_cost(int unsigned ci, int unsigned cj,
                                                  int unsigned d, int unsigned w);
      int unsigned acc, rc;
      int diff;
      acc = 0;
      for (int unsigned r = ci - HALF; r < ci + HALF; r++) begin
         for (int unsigned c = cj - HALF; c < cj + HALF; c++) begin
            rc = (c + d > w - 1) ? w - 1 : c + d;
            diff = int'(left_mem[mem_at(r, c)]) - int'(right_mem[mem_at(r, rc)]);
            acc += diff * diff;
         end
      end
      return COST_W'(acc * 4);
   endfunction

   // queue one pixel pair and the costs it completes
   task automatic push_pixel(input logic [PIX_W-1:0] lp, input logic [PIX_W-1:0] rp);
      int unsigned w, h, ci, cj;
      req_type it;
      rsp_type c;
      w = (width_reg < 1) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
      h = (height_reg < 1) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
      it.left_pixel = lp;
      it.right_pixel = rp;
      pixel_q.insert(pixel_q.size(), it);
      if (col_pos < w) begin
         left_mem[mem_at(row_pos, col_pos)] = lp;
         right_mem[mem_at(row_pos, col_pos)] = rp;
      end
      if (row_pos + 1 >= NROWS && row_pos + 2 <= h && col_pos >= HALF + NDISP - 2) begin
         cj = col_pos - (HALF + NDISP - 2);
         if (cj >= HALF && cj + HALF + 1 <= w) begin
            ci = row_pos + 1 - HALF;
            for (int unsigned d = 0; d < NDISP; d++) begin
               c.match_cost = ssd_cost(ci, cj, d, w);
               c.centre_row = ROW_W'(ci);
               c.centre_col = ROW_W'(cj);
               c.disparity = DISP_W'(d);
               c.last_of_run = (d == NDISP - 1);
               cost_q.insert(cost_q.size(), c);
            end
         end
      end
      if (col_pos + 1 >= w + NDISP - 1) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : ((row_pos + 1) & 10'h3ff);
      end else begin
         col_pos = (col_pos + 1) & 11'h7ff;
      end
   endtask

   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   task automatic feed(input int n);
      for (int k = 0; k < n; k++) push_pixel(pick_pixel(), pick_pixel());
   endtask

   // run on until the counters come back to the top of a frame
   task automatic feed_to_origin();
      do push_pixel(pick_pixel(), pick_pixel());
      while (!(row_pos == 0 && col_pos == 0));
   endtask

   task automatic drain();
      while (pixel_q.size() != 0 || req_valid || cost_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-3:0] idx,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic check_reg(input logic [CSR_ADDR_W-3:0] idx, input logic [CFG_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      csr_access(1'b0, idx, '0, got);
      if (got[CFG_W-1:0] !== want) begin
         $display("%0t register %0d: expected %0d, got %0d", $time, idx, want, got);
         errors++;
      end
   endtask

   task automatic set_reg(input logic [CSR_ADDR_W-3:0] idx, input logic [CFG_W-1:0] v);
      logic [CSR_DATA_W-1:0] dummy;
      csr_access(1'b1, idx, CSR_DATA_W'(v), dummy);
      if (idx == REG_FRAME_WIDTH) width_reg = v;
      else height_reg = v;
      check_reg(idx, v);
   endtask

   // sender: bursts of beats with gaps between
   int burst_left, gap_left;
   always @(posedge clock) req_taken <= req_valid && req_ready;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pixel_q.size() != 0) begin
            req_data <= pixel_q.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern, with one long hold-off while costs are pending
   int hold_left, mode_left, stall_mode;
   logic held_once;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         mode_left <= 0;
         stall_mode <= 0;
         held_once <= 1'b0;
      end else if (!held_once && rsp_valid) begin
         held_once <= 1'b1;
         hold_left <= 3000;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode_left <= $urandom_range(50, 400);
            stall_mode <= $urandom_range(0, 3);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= ($urandom_range(0, 7) != 0);
            default: rsp_ready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   // compare each cost beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (cost_q.size() == 0) begin
            $display("%0t unexpected cost beat: %p", $time, rsp_data);
            errors++;
         end else begin
            automatic rsp_type want = cost_q.pop_front();
            if (rsp_data.match_cost !== want.match_cost ||
                rsp_data.centre_row !== want.centre_row ||
                rsp_data.centre_col !== want.centre_col ||
                rsp_data.disparity !== want.disparity ||
                rsp_data.last_of_run !== want.last_of_run) begin
               $display("%0t cost mismatch: expected %p, got %p", $time, want, rsp_data);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      errors = 0;
      reset = 1'b1;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      width_reg = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      row_pos = 0;
      col_pos = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      check_reg(REG_FRAME_WIDTH, FRAME_WIDTH_RESET);
      check_reg(REG_FRAME_HEIGHT, FRAME_HEIGHT_RESET);

      // shortest frame height that completes windows, opening with flat and full-swing pixels
      set_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(16, 18)));
      set_reg(REG_FRAME_HEIGHT, 11'd11);
      for (int k = 0; k < 12; k++) push_pixel(8'h00, 8'hff);
      for (int k = 0; k < 12; k++) push_pixel(8'hff, 8'h00);
      feed_to_origin();
      drain();

      // out-of-range registers clamp
      set_reg(REG_FRAME_WIDTH, 11'h7ff);
      set_reg(REG_FRAME_HEIGHT, 11'h7ff);
      feed(70);
      drain();
      // width shrunk mid-row: the column is past the new row length
      set_reg(REG_FRAME_WIDTH, 11'd16);
      feed(1);
      drain();
      // height dropped below the current row
      set_reg(REG_FRAME_HEIGHT, 11'd0);
      feed_to_origin();
      drain();
      set_reg(REG_FRAME_WIDTH, 11'd0);
      set_reg(REG_FRAME_HEIGHT, 11'h7ff);
      feed(100);
      drain();
      set_reg(REG_FRAME_HEIGHT, 11'd0);
      feed_to_origin();
      drain();

      if (errors == 0 && cost_q.size() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
`default_nettype wire
